// ===== rtl/etfd_pkg.sv =====
package etfd_pkg;

  localparam int FRAME_BYTES = 10;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int STORE_DEPTH = FRAME_BYTES - 1;

  localparam logic [7:0] CRC_POLY = 8'hD5;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_GOOD = 2'd1;
  localparam logic [1:0] EV_BAD  = 2'd2;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_GOOD = 2'd1;
  localparam logic [1:0] CMD_BAD  = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  localparam int VOLT_FINE   = 10;
  localparam int VOLT_COARSE = 100;
  localparam int CURR_SCALE  = 10;
  localparam int ERPM_SCALE  = 100;

  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  frame_event;
    logic [7:0]  temp_c;
    logic [22:0] voltage_mv;
    logic [19:0] current_ma;
    logic [15:0] consumption_mah;
    logic [22:0] erpm;
    logic        data_valid;
    logic [31:0] crc_error_count;
    logic [31:0] good_frame_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  temp;
    logic [15:0] volt_raw;
    logic [15:0] curr_raw;
    logic [15:0] cons_raw;
    logic [15:0] erpm_raw;
  } cmd_t;

  typedef struct packed {
    logic [15:0] stale_limit_ms;
    logic [19:0] volt_min_mv;
    logic [19:0] volt_max_mv;
  } cfg_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/etfd_front.sv =====
module etfd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  etfd_pkg::req_t req,
  input  logic          full,
  output logic          push,
  output etfd_pkg::cmd_t push_cmd
);
  import etfd_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] byte_index_next;
  logic [7:0]       running_crc;
  logic [7:0]       running_crc_next;
  logic [7:0]       frame_store [STORE_DEPTH];
  logic             store_wr;

  assign req_stall = full;
  assign push      = req_valid && !full;

  always_comb begin
    byte_index_next  = byte_index;
    running_crc_next = running_crc;
    store_wr         = 1'b0;
    push_cmd.kind     = CMD_NONE;
    push_cmd.temp     = frame_store[0];
    push_cmd.volt_raw = {frame_store[1], frame_store[2]};
    push_cmd.curr_raw = {frame_store[3], frame_store[4]};
    push_cmd.cons_raw = {frame_store[5], frame_store[6]};
    push_cmd.erpm_raw = {frame_store[7], frame_store[8]};
    unique case (req.operation)
      OP_BYTE: begin
        if (byte_index < LAST_IDX) begin
          store_wr         = 1'b1;
          running_crc_next = crc8_step(running_crc, req.rx_byte);
          byte_index_next  = byte_index + 1'b1;
        end else begin
          push_cmd.kind    = (running_crc == req.rx_byte) ? CMD_GOOD : CMD_BAD;
          byte_index_next  = '0;
          running_crc_next = '0;
        end
      end
      OP_FLUSH: begin
        byte_index_next  = '0;
        running_crc_next = '0;
      end
      OP_TICK: push_cmd.kind = CMD_TICK;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      running_crc <= '0;
    end else if (push) begin
      byte_index  <= byte_index_next;
      running_crc <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && store_wr) begin
      frame_store[byte_index] <= req.rx_byte;
    end
  end

endmodule

// ===== rtl/etfd_queue.sv =====
module etfd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  etfd_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output etfd_pkg::cmd_t  head,
  output etfd_pkg::qstat_t stat
);
  import etfd_pkg::*;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign stat.count = count;
  assign stat.full  = (count == CNT_FULL);
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/etfd_back.sv =====
module etfd_back (
  input  logic           clk,
  input  logic           rst,
  input  etfd_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  etfd_pkg::cmd_t cmd,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output etfd_pkg::rsp_t rsp
);
  import etfd_pkg::*;

  logic [15:0] age_ms;
  logic [15:0] age_ms_next;
  rsp_t        rsp_next;
  logic [19:0] volt_x10;
  logic [22:0] volt_x100;
  logic        use_coarse;
  logic [15:0] age_inc;

  assign pop = cmd_valid && (!rsp_valid || !rsp_stall);

  assign volt_x10   = 20'(cmd.volt_raw) * 20'(VOLT_FINE);
  assign volt_x100  = 23'(cmd.volt_raw) * 23'(VOLT_COARSE);
  assign use_coarse = (volt_x10 < cfg.volt_min_mv) && (volt_x100 <= 23'(cfg.volt_max_mv));
  assign age_inc    = (age_ms < AGE_MAX) ? age_ms + 1'b1 : age_ms;

  always_comb begin
    rsp_next             = rsp;
    rsp_next.frame_event = EV_NONE;
    age_ms_next          = age_ms;
    unique case (cmd.kind)
      CMD_GOOD: begin
        rsp_next.frame_event      = EV_GOOD;
        rsp_next.temp_c           = cmd.temp;
        rsp_next.voltage_mv       = use_coarse ? volt_x100 : 23'(volt_x10);
        rsp_next.current_ma       = 20'(cmd.curr_raw) * 20'(CURR_SCALE);
        rsp_next.consumption_mah  = cmd.cons_raw;
        rsp_next.erpm             = 23'(cmd.erpm_raw) * 23'(ERPM_SCALE);
        rsp_next.data_valid       = 1'b1;
        rsp_next.good_frame_count = rsp.good_frame_count + 1'b1;
        age_ms_next               = '0;
      end
      CMD_BAD: begin
        rsp_next.frame_event     = EV_BAD;
        rsp_next.crc_error_count = rsp.crc_error_count + 1'b1;
      end
      CMD_TICK: begin
        age_ms_next = age_inc;
        if (rsp.data_valid && (age_inc > cfg.stale_limit_ms)) begin
          rsp_next.data_valid = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      rsp       <= '0;
      age_ms    <= '0;
    end else begin
      if (pop) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
        age_ms    <= age_ms_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/esc_telemetry_frame_decoder.sv =====
// A taken item is written into the queue and then popped into the registered result.
// One item is taken per cycle while the queue is not full (req_stall low); a two-entry
// queue between the front stage and the result stage absorbs result stalls.
// Reset (synchronous, rst high): frame position, CRC, counters, held telemetry, age
// and queue cleared; registers return to 500, 3000 and 60000. Frame bytes need no reset.
module esc_telemetry_frame_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  etfd_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output etfd_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import etfd_pkg::*;

  localparam logic [1:0] REG_STALE = 2'd0;
  localparam logic [1:0] REG_VMIN  = 2'd1;
  localparam logic [1:0] REG_VMAX  = 2'd2;

  cfg_t   cfg;
  logic   push;
  cmd_t   push_cmd;
  logic   pop;
  cmd_t   head;
  qstat_t qstat;
  logic   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stale_limit_ms <= 16'd500;
      cfg.volt_min_mv    <= 20'd3000;
      cfg.volt_max_mv    <= 20'd60000;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_STALE: cfg.stale_limit_ms <= pwdata[15:0];
        REG_VMIN:  cfg.volt_min_mv    <= pwdata[19:0];
        REG_VMAX:  cfg.volt_max_mv    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STALE: prdata = 32'(cfg.stale_limit_ms);
      REG_VMIN:  prdata = 32'(cfg.volt_min_mv);
      REG_VMAX:  prdata = 32'(cfg.volt_max_mv);
      default:   prdata = '0;
    endcase
  end

  etfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .full     (qstat.full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  etfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .stat    (qstat)
  );

  etfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(!qstat.empty),
    .cmd      (head),
    .pop      (pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall == (qstat.count == QCNT_W'(QUEUE_DEPTH)))
    else $error("input stall does not match queue full");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!qstat.empty && !rsp_valid) |=> rsp_valid)
    else $error("queued transfer not moved to output");

  a_good_valid: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.frame_event == EV_GOOD) |-> rsp.data_valid)
    else $error("good frame without data valid");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== tb/sv/etfd_telemetry_checker.sv =====
package etfd_tb_pkg;

  localparam logic [3:0] ADDR_STALE_LIMIT = 4'h0;
  localparam logic [3:0] ADDR_VOLT_MIN    = 4'h4;
  localparam logic [3:0] ADDR_VOLT_MAX    = 4'h8;

  // operation code that leaves the frame state unchanged and yields no event
  localparam logic [1:0] OP_SPARE = 2'd3;

  // CRC8 DVB-S2, fed MSB first one bit at a time
  function automatic logic [7:0] crc8_dvbs2(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    int         k;
    r = acc;
    for (k = 7; k >= 0; k--) begin
      fb = r[7] ^ data[k];
      r = {r[6:0], 1'b0} ^ (fb ? etfd_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

endpackage

module etfd_telemetry_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  etfd_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  etfd_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic           pready,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output int             errors,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import etfd_pkg::*;
  import etfd_tb_pkg::*;

  rsp_t        expected_readings [$];
  rsp_t        shown;
  logic [3:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  frame_buf [STORE_DEPTH];
  logic [15:0] age_ms;
  logic [15:0] stale_limit;
  logic [19:0] volt_min;
  logic [19:0] volt_max;
  int          results_seen;

  task automatic clear_state();
    int i;
    frame_pos = '0;
    crc_acc = '0;
    for (i = 0; i < STORE_DEPTH; i++) frame_buf[i] = '0;
    shown = '0;
    age_ms = '0;
    stale_limit = 16'd500;
    volt_min = 20'd3000;
    volt_max = 20'd60000;
    expected_readings.delete();
    pending = 0;
    errors = 0;
    results_seen = 0;
  endtask

  task automatic decode_event(input req_t item, output rsp_t reading);
    logic [31:0] raw;
    logic [31:0] fine_mv;
    logic [31:0] coarse_mv;
    logic [31:0] scaled;
    shown.frame_event = EV_NONE;
    case (item.operation)
      OP_BYTE: begin
        if (frame_pos < STORE_DEPTH) begin
          frame_buf[frame_pos] = item.rx_byte;
          crc_acc = crc8_dvbs2(crc_acc, item.rx_byte);
          frame_pos = frame_pos + 4'd1;
        end else begin
          if (crc_acc == item.rx_byte) begin
            raw = {16'h0, frame_buf[1], frame_buf[2]};
            fine_mv = raw * VOLT_FINE;
            coarse_mv = raw * VOLT_COARSE;
            shown.frame_event = EV_GOOD;
            shown.temp_c = frame_buf[0];
            shown.voltage_mv = (fine_mv < volt_min && coarse_mv <= volt_max) ?
                               coarse_mv[22:0] : fine_mv[22:0];
            scaled = {16'h0, frame_buf[3], frame_buf[4]} * CURR_SCALE;
            shown.current_ma = scaled[19:0];
            shown.consumption_mah = {frame_buf[5], frame_buf[6]};
            scaled = {16'h0, frame_buf[7], frame_buf[8]} * ERPM_SCALE;
            shown.erpm = scaled[22:0];
            shown.data_valid = 1'b1;
            age_ms = '0;
            shown.good_frame_count = shown.good_frame_count + 32'd1;
          end else begin
            shown.frame_event = EV_BAD;
            shown.crc_error_count = shown.crc_error_count + 32'd1;
          end
          frame_pos = '0;
          crc_acc = '0;
        end
      end
      OP_FLUSH: begin
        frame_pos = '0;
        crc_acc = '0;
      end
      OP_TICK: begin
        if (age_ms != AGE_MAX) age_ms = age_ms + 16'd1;
        if (shown.data_valid && age_ms > stale_limit) shown.data_valid = 1'b0;
      end
      default: ;
    endcase
    reading = shown;
  endtask

  task automatic report_mismatch(input string what);
    if (errors < 200) $display("%0t: telemetry transfer %0d: %s", $time, results_seen, what);
    errors = errors + 1;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    rsp_t reading;
    if (rst) begin
      clear_state();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("transfer with no reading expected");
        end else begin
          reading = expected_readings.pop_front();
          pending = pending - 1;
          check_field("frame_event", 32'(rsp.frame_event), 32'(reading.frame_event));
          check_field("temp_c", 32'(rsp.temp_c), 32'(reading.temp_c));
          check_field("voltage_mv", 32'(rsp.voltage_mv), 32'(reading.voltage_mv));
          check_field("current_ma", 32'(rsp.current_ma), 32'(reading.current_ma));
          check_field("consumption_mah", 32'(rsp.consumption_mah),
                      32'(reading.consumption_mah));
          check_field("erpm", 32'(rsp.erpm), 32'(reading.erpm));
          check_field("data_valid", 32'(rsp.data_valid), 32'(reading.data_valid));
          check_field("crc_error_count", rsp.crc_error_count, reading.crc_error_count);
          check_field("good_frame_count", rsp.good_frame_count, reading.good_frame_count);
        end
        results_seen = results_seen + 1;
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_STALE_LIMIT: stale_limit = pwdata[15:0];
          ADDR_VOLT_MIN:    volt_min = pwdata[19:0];
          ADDR_VOLT_MAX:    volt_max = pwdata[19:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        decode_event(req, reading);
        expected_readings.push_back(reading);
        pending = pending + 1;
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etfd_pkg::*;
  import etfd_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PHASE_ITEMS     = 320;
  localparam int HOLD_OFF_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int items_sent = 0;
  int cycles = 0;
  bit sender_eager = 1'b0;
  bit drain_eager = 1'b0;

  esc_telemetry_frame_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  etfd_telemetry_checker telemetry_chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("esc_telemetry_frame_decoder: mismatch");
      $finish;
    end
  end

  function automatic int pick_wait(input bit eager);
    if (eager || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] stale, input logic [19:0] vmin,
                           input logic [19:0] vmax);
    reg_write(ADDR_STALE_LIMIT, {16'h0, stale});
    reg_write(ADDR_VOLT_MIN, {12'h0, vmin});
    reg_write(ADDR_VOLT_MAX, {12'h0, vmax});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait until every transfer has drained
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] data);
    req_t item;
    int   gap;
    item.operation = op;
    item.rx_byte = data;
    gap = pick_wait(sender_eager);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (op != OP_SPARE) items_sent++;
  endtask

  // body holds frame bytes 0..8, byte 0 in the top bits
  task automatic send_frame(input logic [71:0] body, input logic [7:0] crc_flip);
    logic [7:0] acc;
    int         i;
    acc = '0;
    for (i = 0; i < STORE_DEPTH; i++) begin
      send_item(OP_BYTE, body[71 - 8*i -: 8]);
      acc = crc8_dvbs2(acc, body[71 - 8*i -: 8]);
    end
    send_item(OP_BYTE, acc ^ crc_flip);
  endtask

  task automatic send_random_frame(input bit corrupt);
    logic [71:0] body;
    logic [15:0] raw;
    logic [7:0]  flip;
    int          i;
    for (i = 0; i < STORE_DEPTH; i++) body[71 - 8*i -: 8] = 8'($urandom_range(0, 255));
    // bias the voltage toward the scale decision
    case ($urandom_range(0, 3))
      0: raw = 16'($urandom_range(0, 400));
      1: raw = 16'($urandom_range(0, 11000));
      default: raw = body[63:48];
    endcase
    body[63:48] = raw;
    flip = corrupt ? 8'($urandom_range(1, 255)) : 8'h00;
    send_frame(body, flip);
  endtask

  initial begin
    int stall_cycles;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 500 || taken == 1300) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall_cycles = pick_wait(drain_eager);
      if (stall_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int phase;
    int target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    configure(16'd1, 20'd3000, 20'd60000);

    // good frame: max temp, coarse voltage, max current and erpm
    send_frame(72'hFF_00C8_FFFF_0000_FFFF, 8'h00);
    send_item(OP_SPARE, 8'hA5);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_BYTE, 8'h12);
    send_item(OP_FLUSH, 8'h5A);
    send_frame(72'h0, 8'h80);

    for (phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: configure(16'd3, 20'd3000, 20'd60000);
        1: configure(16'd0, 20'd0, 20'hFFFFF);
        2: configure(16'hFFFF, 20'hFFFFF, 20'hFFFFF);
        3: configure(16'd40, 20'd500000, 20'd0);
        4: configure(16'd500, 20'd3000, 20'd60000);
        default: configure(16'd7, 20'd20000, 20'd200000);
      endcase
      sender_eager = (phase == 2);
      drain_eager = (phase == 2);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_random_frame(1'b0);
          5: send_random_frame(1'b1);
          6: repeat ($urandom_range(1, 12)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
          7: begin
            repeat ($urandom_range(1, 9)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
            send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
          end
          8: send_item(OP_SPARE, 8'($urandom_range(0, 255)));
          default: begin
            repeat ($urandom_range(1, 4))
              send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
          end
        endcase
      end
    end

    // top stale limit: valid holds across ticks
    settle();
    configure(16'hFFFF, 20'd3000, 20'd60000);
    sender_eager = 1'b1;
    drain_eager = 1'b1;
    send_random_frame(1'b0);
    repeat (20) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    settle();
    configure(16'hFFFE, 20'd3000, 20'd60000);
    send_item(OP_TICK, 8'($urandom_range(0, 255)));
    send_item(OP_TICK, 8'($urandom_range(0, 255)));
    settle();
    repeat (4) @(posedge clk);

    if (errors == 0) begin
      $display("esc_telemetry_frame_decoder: match");
    end else begin
      $display("esc_telemetry_frame_decoder: mismatch");
    end
    $finish;
  end

endmodule
